// ===== rtl/uerc_pkg.sv =====
// Shared types, phase codes and constants for the ultrasonic echo ranging controller.
`timescale 1ns / 1ps

package uerc_pkg;

    localparam int unsigned PhaseW = 3;
    localparam int unsigned UsW    = 17;
    localparam int unsigned EchoW  = 16;
    localparam int unsigned DistW  = 19;
    localparam int unsigned ProdW  = 27;

    localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
    localparam logic [PhaseW-1:0] PH_SETTLE = 3'd1;
    localparam logic [PhaseW-1:0] PH_TRIG   = 3'd2;
    localparam logic [PhaseW-1:0] PH_RISE   = 3'd3;
    localparam logic [PhaseW-1:0] PH_FALL   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RISE_TOUT = 2'd1;
    localparam logic [1:0] ST_FALL_TOUT = 2'd2;

    localparam logic [UsW-1:0] US_MAX   = 17'h1FFFF;
    localparam logic [10:0]    DIST_MUL = 11'd1124;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CLKS_PER_US = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_US  = 2'd1;
    localparam logic [1:0] REG_TRIG_US     = 2'd2;
    localparam logic [1:0] REG_SETTLE_US   = 2'd3;

    localparam logic [7:0]  CLKS_PER_US_RST = 8'd72;
    localparam logic [15:0] TIMEOUT_US_RST  = 16'd30000;
    localparam logic [7:0]  TRIG_US_RST     = 8'd10;
    localparam logic [7:0]  SETTLE_US_RST   = 8'd2;

    typedef struct packed {
        logic [7:0]  clks_per_us;
        logic [15:0] timeout_us;
        logic [7:0]  trig_us;
        logic [7:0]  settle_us;
    } uerc_cfg_t;

    typedef struct packed {
        logic [DistW-1:0] distance_q8;
        logic [EchoW-1:0] echo_time_us;
        logic [1:0]       status;
        logic             done_res;
        logic             busy_res;
        logic             trig_level;
    } uerc_result_t;

endpackage

// ===== rtl/uerc_seq.sv =====
// Trigger and echo timing sequencer: one tick per accepted transaction.
`timescale 1ns / 1ps

module uerc_seq
    import uerc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic         op,
    input  logic         echo_level,
    input  uerc_cfg_t    cfg,
    output uerc_result_t result
);

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [7:0]        pre_reg, pre_next;
    logic [UsW-1:0]    us_reg, us_next;
    logic [EchoW-1:0]  held_echo_reg, held_echo_next;
    logic [1:0]        held_status_reg, held_status_next;
    logic [DistW-1:0]  held_dist_reg, held_dist_next;
    logic              done;

    logic [7:0]       div;
    logic [7:0]       adv_pre_inc;
    logic             adv_wrap;
    logic [7:0]       adv_pre;
    logic [UsW-1:0]   adv_us;
    logic             timeout;
    logic [ProdW-1:0] dist_prod;

    assign div         = (cfg.clks_per_us == 8'd0) ? 8'd1 : cfg.clks_per_us;
    assign adv_pre_inc = pre_reg + 8'd1;
    assign adv_wrap    = (adv_pre_inc >= div);
    assign adv_pre     = adv_wrap ? 8'd0 : adv_pre_inc;
    assign adv_us      = (adv_wrap && us_reg != US_MAX) ? us_reg + 17'd1 : us_reg;

    // The prescaler always stays below the divisor during a wait, so comparing
    // whole microseconds and then the leftover cycles is the same as comparing
    // total cycles against timeout_us * clks_per_us.
    assign timeout = (us_reg > {1'b0, cfg.timeout_us}) ||
                     ((us_reg == {1'b0, cfg.timeout_us}) && (pre_reg != 8'd0));

    assign dist_prod = ProdW'(us_reg[EchoW-1:0]) * ProdW'(DIST_MUL);

    always_comb begin
        phase_next       = phase_reg;
        pre_next         = pre_reg;
        us_next          = us_reg;
        held_echo_next   = held_echo_reg;
        held_status_next = held_status_reg;
        held_dist_next   = held_dist_reg;
        done             = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (op) begin
                    phase_next = PH_SETTLE;
                    pre_next   = 8'd0;
                    us_next    = '0;
                end
            end
            PH_SETTLE: begin
                pre_next = adv_pre;
                us_next  = adv_us;
                if (adv_us >= {9'd0, cfg.settle_us}) begin
                    phase_next = PH_TRIG;
                    pre_next   = 8'd0;
                    us_next    = '0;
                end
            end
            PH_TRIG: begin
                pre_next = adv_pre;
                us_next  = adv_us;
                if (adv_us >= {9'd0, cfg.trig_us}) begin
                    phase_next = PH_RISE;
                    pre_next   = 8'd0;
                    us_next    = '0;
                end
            end
            PH_RISE: begin
                if (echo_level) begin
                    // The rising tick counts as the first high cycle.
                    phase_next = PH_FALL;
                    if (div == 8'd1) begin
                        pre_next = 8'd0;
                        us_next  = 17'd1;
                    end else begin
                        pre_next = 8'd1;
                        us_next  = '0;
                    end
                end else if (timeout) begin
                    held_status_next = ST_RISE_TOUT;
                    phase_next       = PH_IDLE;
                    done             = 1'b1;
                end else begin
                    pre_next = adv_pre;
                    us_next  = adv_us;
                end
            end
            PH_FALL: begin
                if (!echo_level) begin
                    held_echo_next   = us_reg[EchoW-1:0];
                    held_dist_next   = dist_prod[ProdW-1:8];
                    held_status_next = ST_OK;
                    phase_next       = PH_IDLE;
                    done             = 1'b1;
                end else if (timeout) begin
                    held_status_next = ST_FALL_TOUT;
                    phase_next       = PH_IDLE;
                    done             = 1'b1;
                end else begin
                    pre_next = adv_pre;
                    us_next  = adv_us;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                pre_next   = 8'd0;
                us_next    = '0;
            end
        endcase
    end

    always_comb begin
        result.trig_level   = (phase_next == PH_TRIG);
        result.busy_res     = (phase_next != PH_IDLE);
        result.done_res     = done;
        result.status       = held_status_next;
        result.echo_time_us = held_echo_next;
        result.distance_q8  = held_dist_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            pre_reg         <= 8'd0;
            us_reg          <= '0;
            held_echo_reg   <= '0;
            held_status_reg <= ST_OK;
            held_dist_reg   <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            pre_reg         <= pre_next;
            us_reg          <= us_next;
            held_echo_reg   <= held_echo_next;
            held_status_reg <= held_status_next;
            held_dist_reg   <= held_dist_next;
        end
    end

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_IDLE && op |=> phase_reg == PH_SETTLE && us_reg == '0)
        else $error("start request did not enter the settle phase");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(phase_reg) && $stable(us_reg) && $stable(pre_reg))
        else $error("sequencer state moved without a transaction");

    a_fall_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_FALL && !echo_level
        |=> phase_reg == PH_IDLE && held_status_reg == ST_OK &&
            held_echo_reg == $past(us_reg[EchoW-1:0]))
        else $error("echo fall did not capture the measurement");

    a_rise_tout: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_RISE && !echo_level && timeout
        |=> phase_reg == PH_IDLE && held_status_reg == ST_RISE_TOUT)
        else $error("rise timeout not reported");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done |=> phase_reg == PH_IDLE)
        else $error("done without returning to idle");

endmodule

// ===== rtl/ultrasonic_echo_ranging_controller.sv =====
// Top level: stream channels, APB register file and result register.
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// s_        | in        | tuser[0] op; tdata[0] echo_level
// m_        | out       | tdata: trig_level, busy_res, done_res, status, echo_time_us,
//           |           |        distance_q8 (lowest bit first)
// APB       | in/out    | clks_per_us @0x0, timeout_us @0x4, trig_us @0x8, settle_us @0xC
//
// One transaction is accepted every cycle unless the output stalls; its result appears
// in the output register on the next cycle. The sequencer next-state logic and the
// distance multiply are combinational between the input handshake and that register.
// A stalled output blocks input only while the output register is full and not taken.
// Reset clears all state but the output data, and the registers return to their defaults.

module ultrasonic_echo_ranging_controller
    import uerc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] echo_level, rest zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] trig_level, [1] busy_res, [2] done_res,
                                   // [4:3] status, [20:5] echo_time_us, [39:21] distance_q8
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    uerc_cfg_t    cfg_reg;
    uerc_result_t result;
    logic         m_tvalid_reg;
    logic [39:0]  m_tdata_reg;
    logic         accept;
    logic         cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clks_per_us <= CLKS_PER_US_RST;
            cfg_reg.timeout_us  <= TIMEOUT_US_RST;
            cfg_reg.trig_us     <= TRIG_US_RST;
            cfg_reg.settle_us   <= SETTLE_US_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CLKS_PER_US: cfg_reg.clks_per_us <= pwdata[7:0];
                REG_TIMEOUT_US:  cfg_reg.timeout_us  <= pwdata[15:0];
                REG_TRIG_US:     cfg_reg.trig_us     <= pwdata[7:0];
                REG_SETTLE_US:   cfg_reg.settle_us   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLKS_PER_US: prdata = {24'd0, cfg_reg.clks_per_us};
            REG_TIMEOUT_US:  prdata = {16'd0, cfg_reg.timeout_us};
            REG_TRIG_US:     prdata = {24'd0, cfg_reg.trig_us};
            REG_SETTLE_US:   prdata = {24'd0, cfg_reg.settle_us};
            default:         prdata = 32'd0;
        endcase
    end

    uerc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_tuser[0]),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= result;
        end
    end

endmodule
